// ===== rtl/chacha_pkg.sv =====
// Shared types, constants and functions for the ChaCha20 stream cipher.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps
package chacha_pkg;

	localparam int DoubleRoundsDefault = 10;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;

	// Register indexes of the configuration port.
	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY01   = 3'd0,
		REG_KEY23   = 3'd1,
		REG_KEY45   = 3'd2,
		REG_KEY67   = 3'd3,
		REG_NONCE01 = 3'd4,
		REG_NONCE2  = 3'd5
	} cfg_reg_t;

	localparam logic [31:0] Sigma0 = 32'h61707865;
	localparam logic [31:0] Sigma1 = 32'h3320646e;
	localparam logic [31:0] Sigma2 = 32'h79622d32;
	localparam logic [31:0] Sigma3 = 32'h6b206574;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL,
		ST_OUT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // load initial state from key, nonce, counter
		logic round;      // run one half double round (column or diagonal)
		logic diag;       // selects diagonal round
		logic finish;     // feed-forward add into keystream block
		logic take;       // capture the input beat and form the output byte
		logic clr_count;  // restart counter at zero before loading
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_block; // next byte needs a fresh block
	} dp_status_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	// One quarter round on four words.
	function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] a1, b1, c1, d1;
		a1 = a + b;   d1 = rotl(d ^ a1, 16);
		c1 = c + d1;  b1 = rotl(b ^ c1, 12);
		a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
		c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
		qround = {d1, c1, b1, a1};
	endfunction

endpackage

// ===== rtl/chacha_ctrl.sv =====
// Controller state machine for the ChaCha20 stream cipher.
// Depends on chacha_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps
module chacha_ctrl #(
	parameter int DOUBLE_ROUNDS = chacha_pkg::DoubleRoundsDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_first,
	output logic                   in_ready,
	input  logic                   out_busy,
	input  chacha_pkg::dp_status_t status,
	output chacha_pkg::dp_cmd_t    cmd
);
	import chacha_pkg::*;

	localparam int HalfRounds = 2 * DOUBLE_ROUNDS;
	localparam int CntW = $clog2(HalfRounds + 1);

	ctrl_state_t state_q, state_d;
	logic [CntW-1:0] rnd_q;
	logic need;

	assign need = status.need_block || in_first;

	// State register and round counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				rnd_q <= '0;
			end else if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid && need && !out_busy) state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == CntW'(HalfRounds - 1)) state_d = ST_FINAL;
			ST_FINAL: state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid && need && !out_busy;
				cmd.clr_count = in_first;
				in_ready = !need && !out_busy;
				cmd.take = in_valid && !need && !out_busy;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				cmd.diag = rnd_q[0];
			end
			ST_FINAL: cmd.finish = 1'b1;
			ST_OUT: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_round_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINAL |-> $past(rnd_q) == CntW'(HalfRounds - 1))
		else $error("round count mismatch");
	a_out_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINAL |=> state_q == ST_OUT)
		else $error("final not followed by out");
	a_no_take_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> !in_ready)
		else $error("ready during rounds");
`endif
endmodule

// ===== rtl/chacha_dp.sv =====
// Datapath for the ChaCha20 stream cipher: state words, four quarter-round
// units, counters, key store and output register. Depends on chacha_pkg.
`timescale 1ns / 1ps
module chacha_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [chacha_pkg::CfgIdxW-1:0]       cfg_idx,
	input  logic [chacha_pkg::CfgDataW-1:0]      cfg_data,
	input  chacha_pkg::dp_cmd_t                  cmd,
	output chacha_pkg::dp_status_t               status,
	input  logic [7:0]                           in_byte,
	input  logic                                 in_first,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [7:0]                           out_byte
);
	import chacha_pkg::*;

	logic [31:0] key_q [8];
	logic [31:0] nonce_q [3];
	logic [31:0] w_q [16];
	logic [31:0] init_q [16];
	logic [31:0] ctr_q;
	logic [5:0]  pos_q;
	logic        valid_q;
	logic        ov_q;
	logic [7:0]  ob_q;
	logic [31:0] nw [16];
	logic [31:0] cur_ctr;
	logic [31:0] ks_word;
	logic [127:0] q0, q1, q2, q3;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) key_q[i] <= '0;
			for (int i = 0; i < 3; i++) nonce_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_KEY01:   begin key_q[0] <= cfg_data[31:0]; key_q[1] <= cfg_data[63:32]; end
				REG_KEY23:   begin key_q[2] <= cfg_data[31:0]; key_q[3] <= cfg_data[63:32]; end
				REG_KEY45:   begin key_q[4] <= cfg_data[31:0]; key_q[5] <= cfg_data[63:32]; end
				REG_KEY67:   begin key_q[6] <= cfg_data[31:0]; key_q[7] <= cfg_data[63:32]; end
				REG_NONCE01: begin nonce_q[0] <= cfg_data[31:0]; nonce_q[1] <= cfg_data[63:32]; end
				REG_NONCE2:  nonce_q[2] <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign cur_ctr = cmd.clr_count ? 32'd0 : ctr_q;

	// Four quarter-round units, columns or diagonals.
	always_comb begin
		if (!cmd.diag) begin
			q0 = qround(w_q[0], w_q[4], w_q[8],  w_q[12]);
			q1 = qround(w_q[1], w_q[5], w_q[9],  w_q[13]);
			q2 = qround(w_q[2], w_q[6], w_q[10], w_q[14]);
			q3 = qround(w_q[3], w_q[7], w_q[11], w_q[15]);
			{nw[12], nw[8],  nw[4], nw[0]} = q0;
			{nw[13], nw[9],  nw[5], nw[1]} = q1;
			{nw[14], nw[10], nw[6], nw[2]} = q2;
			{nw[15], nw[11], nw[7], nw[3]} = q3;
		end else begin
			q0 = qround(w_q[0], w_q[5], w_q[10], w_q[15]);
			q1 = qround(w_q[1], w_q[6], w_q[11], w_q[12]);
			q2 = qround(w_q[2], w_q[7], w_q[8],  w_q[13]);
			q3 = qround(w_q[3], w_q[4], w_q[9],  w_q[14]);
			{nw[15], nw[10], nw[5], nw[0]} = q0;
			{nw[12], nw[11], nw[6], nw[1]} = q1;
			{nw[13], nw[8],  nw[7], nw[2]} = q2;
			{nw[14], nw[9],  nw[4], nw[3]} = q3;
		end
	end

	// Working state and saved input state.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			init_q[0] <= Sigma0; init_q[1] <= Sigma1;
			init_q[2] <= Sigma2; init_q[3] <= Sigma3;
			w_q[0] <= Sigma0; w_q[1] <= Sigma1; w_q[2] <= Sigma2; w_q[3] <= Sigma3;
			for (int i = 0; i < 8; i++) begin
				init_q[4+i] <= key_q[i];
				w_q[4+i] <= key_q[i];
			end
			init_q[12] <= cur_ctr;
			w_q[12] <= cur_ctr;
			for (int i = 0; i < 3; i++) begin
				init_q[13+i] <= nonce_q[i];
				w_q[13+i] <= nonce_q[i];
			end
		end else if (cmd.round) begin
			for (int i = 0; i < 16; i++) w_q[i] <= nw[i];
		end else if (cmd.finish) begin
			for (int i = 0; i < 16; i++) w_q[i] <= w_q[i] + init_q[i];
		end
	end

	// Counter, byte position and block valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
			pos_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				ctr_q <= cur_ctr + 32'd1;
				pos_q <= '0;
			end
			if (cmd.finish) valid_q <= 1'b1;
			if (cmd.take) begin
				pos_q <= pos_q + 6'd1;
				if (pos_q == 6'd63) valid_q <= 1'b0;
			end
		end
	end

	assign ks_word = w_q[pos_q[5:2]];

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.take) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) ob_q <= in_byte ^ ks_word[{pos_q[1:0], 3'b000} +: 8];
	end

	assign status.need_block = !valid_q || in_first;
	assign out_valid = ov_q;
	assign out_byte = ob_q;

`ifndef SYNTH
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> valid_q)
		else $error("byte taken without keystream");
	a_ctr_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> ctr_q == $past(cur_ctr) + 32'd1)
		else $error("counter step wrong");
	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && pos_q == 6'd63) |=> !valid_q)
		else $error("block not retired");
`endif
endmodule

// ===== rtl/chacha20_stream_cipher_top.sv =====
// Channel    Dir  Payload
// s_axis     in   tdata[7:0]=data_byte, tuser[0]=first_of_message
// m_axis     out  tdata[7:0]=out_byte
// cfg        in   cfg_we, cfg_idx[2:0], cfg_data[63:0]
// Bytes within a block need no new keystream; a new block takes 2*DOUBLE_ROUNDS
// rounds (one column or diagonal round per cycle in four quarter-round units,
// then the feed-forward add). The block is computed when the byte needing it
// arrives. Reset clears counter, position and valid flags. The output register
// holds a byte until taken; a new beat is taken only when it is free or freed.
// Top level of the ChaCha20 stream cipher; depends on chacha_pkg, chacha_ctrl
// and chacha_dp.
`timescale 1ns / 1ps
module chacha20_stream_cipher_top #(
	parameter int DOUBLE_ROUNDS = chacha_pkg::DoubleRoundsDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // data_byte
	input  logic                              s_axis_tuser,  // first_of_message
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [7:0]                        m_axis_tdata,  // out_byte
	input  logic                              cfg_we,
	input  logic [chacha_pkg::CfgIdxW-1:0]    cfg_idx,
	input  logic [chacha_pkg::CfgDataW-1:0]   cfg_data
);
	import chacha_pkg::*;

	dp_cmd_t cmd;
	dp_status_t status;
	logic out_busy;

	// Output slot is busy when it holds a beat that is not taken this cycle.
	assign out_busy = m_axis_tvalid && !m_axis_tready;

	chacha_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_first(s_axis_tuser), .in_ready(s_axis_tready),
		.out_busy(out_busy), .status(status), .cmd(cmd)
	);

	chacha_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.cmd(cmd), .status(status),
		.in_byte(s_axis_tdata), .in_first(s_axis_tuser),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_byte(m_axis_tdata)
	);
endmodule
